// ===== design/lisq_pkg.sv =====
// Shared types and codes for the log index / sequence number map queue.
// Holds the channel payload structs, command and status codes, and FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lisq_pkg;

  localparam int unsigned LOG_W   = 63;
  localparam int unsigned SEQ_W   = 56;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned MASK_W  = 20;

  // Command codes on the request channel
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_PURGE  = 2'd2;

  // Status codes on the response channel
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [LOG_W-1:0] log_idx;
    logic [SEQ_W-1:0] seq_number;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [LOG_W-1:0]   found_index;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    K_APPEND,
    K_SKIP,
    K_LOOKUP,
    K_PURGE,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [LOG_W-1:0] log_idx;
    logic [SEQ_W-1:0] seq_number;
  } job_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_FIRST,
    S_LK_LAST,
    S_BS_ISSUE,
    S_BS_CMP,
    S_FIX,
    S_FOUND,
    S_PG_ISSUE,
    S_PG_CHK,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== design/lisq_front.sv =====
// Front end: accepts request items, classifies them and queues jobs.
// Depends on lisq_pkg for the request and job types.
`timescale 1ns / 1ps
`default_nettype none

module lisq_front import lisq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  input  wire logic [MASK_W-1:0] sample_mask,
  output logic                   job_valid,
  input  wire logic              job_pop,
  output job_t                   job
);

  job_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  job_t       cls;

  // Classify: sampling check on appends, unused command becomes a no-op
  always_comb begin
    cls.log_idx    = req.log_idx;
    cls.seq_number = req.seq_number;
    unique case (req.cmd)
      CMD_APPEND: begin
        if ((req.log_idx[MASK_W-1:0] & sample_mask) != '0) cls.kind = K_SKIP;
        else cls.kind = K_APPEND;
      end
      CMD_LOOKUP: cls.kind = K_LOOKUP;
      CMD_PURGE:  cls.kind = K_PURGE;
      default:    cls.kind = K_NOP;
    endcase
  end

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign job_valid = (fill != 2'd0);
  assign job       = fifo[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cls;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (job_pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, job_pop};
    end
  end

endmodule

`default_nettype wire

// ===== design/lisq_back.sv =====
// Back end: ring store and sequencer for append, lookup and purge.
// Depends on lisq_pkg; holds the pair memory and the response register.
`timescale 1ns / 1ps
`default_nettype none

module lisq_back import lisq_pkg::*; #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      job_pop,
  input  wire job_t job,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

  logic [LOG_W-1:0] mem_log [RING_DEPTH];
  logic [SEQ_W-1:0] mem_seq [RING_DEPTH];

  state_t           state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    lo, lo_next;
  logic [CW-1:0]    span, span_next;
  logic [CW-1:0]    half, half_next;
  logic [CW-1:0]    hit, hit_next;
  logic [1:0]       status, status_next;
  logic [LOG_W-1:0] found, found_next;
  logic [LOG_W-1:0] bound, bound_next;
  logic [SEQ_W-1:0] query, query_next;
  logic [CW-1:0]    rd_pos;
  logic [AW-1:0]    rd_slot;
  logic [AW-1:0]    wr_slot;
  logic             wr_en;
  logic [LOG_W-1:0] rd_log;
  logic [SEQ_W-1:0] rd_seq;
  logic [CW-1:0]    mid;
  logic             rsp_load;

  // Map a position from the head onto a ring slot
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(h) + SW'(pos);
    if (sum >= SW'(RING_DEPTH)) sum = sum - SW'(RING_DEPTH);
    return sum[AW-1:0];
  endfunction

  assign rd_slot  = slot_of(head, rd_pos);
  assign wr_slot  = slot_of(head, count);
  assign mid      = lo + (span >> 1);
  assign rsp_load = (state == S_RESULT) && (!rsp_valid || !rsp_stall);

  // Pair store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_log[wr_slot] <= job.log_idx;
      mem_seq[wr_slot] <= job.seq_number;
    end
    rd_log <= mem_log[rd_slot];
    rd_seq <= mem_seq[rd_slot];
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    lo_next     = lo;
    span_next   = span;
    half_next   = half;
    hit_next    = hit;
    status_next = status;
    found_next  = found;
    bound_next  = bound;
    query_next  = query;
    rd_pos      = '0;
    wr_en       = 1'b0;
    job_pop     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          job_pop     = 1'b1;
          status_next = ST_DONE;
          found_next  = '0;
          bound_next  = job.log_idx;
          query_next  = job.seq_number;
          state_next  = S_RESULT;
          unique case (job.kind)
            K_APPEND: begin
              if (count >= DEPTH_C) begin
                status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            K_SKIP: status_next = ST_SKIP;
            K_LOOKUP: begin
              if (job.seq_number != '0 && count != '0) state_next = S_LK_FIRST;
            end
            K_PURGE: state_next = S_PG_ISSUE;
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_LK_FIRST: begin
        if (query < rd_seq) begin
          state_next = S_RESULT;
        end else begin
          rd_pos     = count - 1'b1;
          state_next = S_LK_LAST;
        end
      end
      S_LK_LAST: begin
        if (query >= rd_seq) begin
          found_next = rd_log;
          state_next = S_RESULT;
        end else begin
          lo_next    = '0;
          span_next  = count;
          state_next = S_BS_ISSUE;
        end
      end
      S_BS_ISSUE: begin
        if (span == '0) begin
          hit_next   = (lo >= count) ? count - 1'b1 : lo;
          rd_pos     = hit_next;
          state_next = S_FIX;
        end else begin
          half_next  = span >> 1;
          rd_pos     = mid;
          state_next = S_BS_CMP;
        end
      end
      S_BS_CMP: begin
        // Probe was at lo + half
        if (rd_seq <= query) begin
          lo_next   = lo + half + 1'b1;
          span_next = span - half - 1'b1;
        end else begin
          span_next = half;
        end
        state_next = S_BS_ISSUE;
      end
      S_FIX: begin
        if (rd_seq > query && hit != '0) begin
          rd_pos     = hit - 1'b1;
          state_next = S_FOUND;
        end else begin
          found_next = rd_log;
          state_next = S_RESULT;
        end
      end
      S_FOUND: begin
        found_next = rd_log;
        state_next = S_RESULT;
      end
      S_PG_ISSUE: begin
        if (count >= CW'(2)) begin
          rd_pos     = CW'(1);
          state_next = S_PG_CHK;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_PG_CHK: begin
        // Pop the head while the second pair is within the bound
        if (rd_log <= bound) begin
          head_next  = slot_of(head, CW'(1));
          count_next = count - 1'b1;
          state_next = S_PG_ISSUE;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    span   <= span_next;
    half   <= half_next;
    hit    <= hit_next;
    status <= status_next;
    found  <= found_next;
    bound  <= bound_next;
    query  <= query_next;
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status      <= status;
      rsp.found_index <= found;
      rsp.entry_count <= COUNT_W'(count);
    end
  end

endmodule

`default_nettype wire

// ===== design/log_index_seqno_map_queue.sv =====
// Ordered ring of (log index, sequence number) pairs with append, lookup, purge.
// Top level: config register, front end (lisq_front) and back end (lisq_back).
// Usage:
//   Request channel req (req_valid / req_stall) carries cmd, log_idx and
//   seq_number; response channel rsp (rsp_valid / rsp_stall) returns one item
//   per request with status, found_index and entry_count, in request order.
//   sample_mask is written through the APB port at byte address 0.
// Timing:
//   A two-entry job queue sits between the front end and the back end, so
//   requests are taken while the back end works. Append, skip and the unused
//   command go from S_IDLE straight to S_RESULT; lookup does one memory read
//   per binary search step (issue, then compare); purge does one memory read
//   per popped pair.
// Reset:
//   rst empties the ring and the queue and clears sample_mask; the pair store
//   itself is not cleared.
// Stall:
//   While rsp_stall is high the response holds; the back end waits with the
//   next result and the queue fills, then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module log_index_seqno_map_queue import lisq_pkg::*; #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [MASK_W-1:0] sample_mask;
  logic              job_valid;
  logic              job_pop;
  job_t              job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(sample_mask) : 32'd0;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mask <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      sample_mask <= pwdata[MASK_W-1:0];
    end
  end

  lisq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .sample_mask (sample_mask),
    .job_valid   (job_valid),
    .job_pop     (job_pop),
    .job         (job)
  );

  lisq_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == COUNT_W'(RING_DEPTH))
    else $error("full drop reported with ring not full");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_DONE |-> rsp.found_index == '0)
    else $error("skipped or dropped append carries a found index");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("channels not cleared by reset");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the log index / sequence number map queue.
// Drives request items, predicts every response from its own ring model, and
// compares them in order. Depends on lisq_pkg and log_index_seqno_map_queue.
`timescale 1ns / 1ps

module tb;
  import lisq_pkg::*;

  localparam int DEPTH = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [LOG_W-1:0] LOG_MAX = '1;
  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;
  localparam logic [2:0] ADDR_SAMPLE_MASK = 3'd0;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  log_index_seqno_map_queue u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow ring and register
  logic [LOG_W-1:0] ring_log [DEPTH];
  logic [SEQ_W-1:0] ring_seq [DEPTH];
  int unsigned ring_head;
  int unsigned ring_count;
  logic [MASK_W-1:0] mask_shadow;

  rsp_t pending_rsp[$];
  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_rcvd;
  int unsigned n_full;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  function automatic int unsigned slot(int unsigned pos);
    return (ring_head + pos) % DEPTH;
  endfunction

  // Binary search for the last pair at or below the query
  function automatic logic [LOG_W-1:0] find_index(logic [SEQ_W-1:0] q);
    int unsigned lo, span, half, mid, hit;
    if (q == '0 || ring_count == 0) return '0;
    if (q < ring_seq[slot(0)]) return '0;
    if (q >= ring_seq[slot(ring_count - 1)]) return ring_log[slot(ring_count - 1)];
    lo = 0;
    span = ring_count;
    while (span > 0) begin
      half = span / 2;
      mid = lo + half;
      if (ring_seq[slot(mid)] <= q) begin
        lo = mid + 1;
        span -= half + 1;
      end else begin
        span = half;
      end
    end
    hit = lo;
    if (hit >= ring_count) hit = ring_count - 1;
    if (ring_seq[slot(hit)] > q && hit > 0) hit--;
    return ring_log[slot(hit)];
  endfunction

  // Apply one item to the shadow ring and return the response it causes
  function automatic rsp_t apply_item(req_t r);
    rsp_t o;
    o = '0;
    o.status = ST_DONE;
    case (r.cmd)
      CMD_APPEND: begin
        if ((r.log_idx[MASK_W-1:0] & mask_shadow) != '0) begin
          o.status = ST_SKIP;
        end else if (ring_count >= DEPTH) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          ring_log[slot(ring_count)] = r.log_idx;
          ring_seq[slot(ring_count)] = r.seq_number;
          ring_count++;
        end
      end
      CMD_LOOKUP: o.found_index = find_index(r.seq_number);
      CMD_PURGE: begin
        while (ring_count >= 2 && ring_log[slot(1)] <= r.log_idx) begin
          ring_head = slot(1);
          ring_count--;
        end
      end
      default: ;
    endcase
    o.entry_count = COUNT_W'(ring_count);
    return o;
  endfunction

  // Send one item; queue either the typed or the predicted response
  task automatic send(req_t r, bit typed = 1'b0, rsp_t want = '0);
    rsp_t p;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    p = apply_item(r);
    if (typed && p !== want) begin
      $display("%0t: table row disagrees with prediction: expected %h, predicted %h",
               $time, want, p);
      errors++;
    end
    pending_rsp.push_back(typed ? want : p);
    n_sent++;
  endtask

  // Drop valid and hold until every response is back
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] m);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_SAMPLE_MASK; pwdata <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mask_shadow = m;
  endtask

  function automatic req_t mk(logic [1:0] c, logic [LOG_W-1:0] li, logic [SEQ_W-1:0] sq);
    req_t r;
    r.cmd = c; r.log_idx = li; r.seq_number = sq;
    return r;
  endfunction

  function automatic rsp_t rs(logic [1:0] st, logic [LOG_W-1:0] fi, int unsigned cnt);
    rsp_t o;
    o.status = st; o.found_index = fi; o.entry_count = COUNT_W'(cnt);
    return o;
  endfunction

  // Receiver stall
  always @(posedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

  // Check each accepted response against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rcvd++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, rsp);
        errors++;
      end else begin
        if (rsp.status !== pending_rsp[0].status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   pending_rsp[0].status, rsp.status);
          errors++;
        end
        if (rsp.found_index !== pending_rsp[0].found_index) begin
          $display("%0t: found_index expected %h got %h", $time,
                   pending_rsp[0].found_index, rsp.found_index);
          errors++;
        end
        if (rsp.entry_count !== pending_rsp[0].entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time,
                   pending_rsp[0].entry_count, rsp.entry_count);
          errors++;
        end
        pending_rsp.delete(0);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d responses outstanding", $time, pending_rsp.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Rising stream with random content, plus noise
  logic [LOG_W-1:0] next_li;
  logic [SEQ_W-1:0] next_seq;

  task automatic random_item();
    int unsigned pick, pos;
    logic [LOG_W-1:0] li;
    logic [SEQ_W-1:0] q;
    pick = $urandom_range(99);
    if (ring_count > 200 && pick < 60) pick = 75;
    if (pick < 45) begin
      next_li = next_li + $urandom_range(1, 8);
      next_seq = next_seq + $urandom_range(1, 5);
      li = next_li;
      if ($urandom_range(1)) li = (next_li | LOG_W'(mask_shadow)) + 1;
      next_li = li;
      send(mk(CMD_APPEND, li, next_seq));
    end else if (pick < 72) begin
      q = '0;
      if (ring_count > 0 && $urandom_range(9) != 0) begin
        pos = $urandom_range(ring_count - 1);
        q = ring_seq[slot(pos)] + $urandom_range(2) - 1;
      end
      send(mk(CMD_LOOKUP, '0, q));
    end else if (pick < 90) begin
      li = '0;
      if (ring_count > 0) begin
        pos = $urandom_range(ring_count > 5 ? 5 : ring_count - 1);
        li = ring_log[slot(pos)] + $urandom_range(2) - 1;
      end
      send(mk(CMD_PURGE, li, '0));
    end else begin
      li = LOG_W'({$urandom, $urandom});
      q = SEQ_W'({$urandom, $urandom});
      send(mk(2'($urandom_range(3)), li, q));
    end
  endtask

  initial begin : main
    req_t rows [$];
    bit typed [$];
    rsp_t wants [$];
    logic [MASK_W-1:0] masks [4];
    int unsigned i, k;

    errors = 0; n_sent = 0; n_rcvd = 0; n_full = 0;
    idle_pct = 0; stall_pct = 0; quiet_cycles = 0;
    ring_head = 0; ring_count = 0; mask_shadow = '0;
    next_li = 100; next_seq = 1000;
    masks = '{20'h0, 20'h3, 20'hFFFFF, 20'h1};

    // Directed table: typed responses where they are obvious
    rows.push_back(mk(CMD_LOOKUP, '0, 5));         typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 0));
    rows.push_back(mk(CMD_PURGE, LOG_MAX, '0));    typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 0));
    rows.push_back(mk(CMD_UNUSED, LOG_MAX, SEQ_MAX)); typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 0));
    rows.push_back(mk(CMD_APPEND, '0, '0));        typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 1));
    rows.push_back(mk(CMD_APPEND, 10, 100));       typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 2));
    rows.push_back(mk(CMD_APPEND, 20, 200));       typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 3));
    rows.push_back(mk(CMD_LOOKUP, '0, '0));        typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 3));
    rows.push_back(mk(CMD_LOOKUP, '0, 50));        typed.push_back(0); wants.push_back('0);
    rows.push_back(mk(CMD_LOOKUP, '0, 100));       typed.push_back(0); wants.push_back('0);
    rows.push_back(mk(CMD_LOOKUP, '0, 1000));      typed.push_back(1); wants.push_back(rs(ST_DONE, 20, 3));
    rows.push_back(mk(CMD_APPEND, 30, 150));       typed.push_back(0); wants.push_back('0);
    rows.push_back(mk(CMD_LOOKUP, '0, 160));       typed.push_back(0); wants.push_back('0);
    rows.push_back(mk(CMD_PURGE, 10, '0));         typed.push_back(0); wants.push_back('0);
    rows.push_back(mk(CMD_LOOKUP, '0, 50));        typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 3));
    rows.push_back(mk(CMD_APPEND, LOG_MAX, SEQ_MAX)); typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 4));
    rows.push_back(mk(CMD_LOOKUP, '0, SEQ_MAX));   typed.push_back(1); wants.push_back(rs(ST_DONE, LOG_MAX, 4));
    rows.push_back(mk(CMD_LOOKUP, '0, 170));       typed.push_back(0); wants.push_back('0);
    rows.push_back(mk(CMD_PURGE, LOG_MAX, '0));    typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 1));
    rows.push_back(mk(CMD_PURGE, LOG_MAX, '0));    typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 1));
    rows.push_back(mk(CMD_LOOKUP, '0, 1));         typed.push_back(1); wants.push_back(rs(ST_DONE, 0, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) send(rows[i], typed[i], wants[i]);
    drain();

    // Random phases, each under its own mask and idling mix
    for (k = 0; k < 4; k++) begin
      write_mask(masks[k]);
      idle_pct = (k == 1 || k == 3) ? 67 : 0;
      stall_pct = (k == 2 || k == 3) ? 67 : 0;
      if (k == 3) begin
        idle_pct = 33; stall_pct = 33;
      end
      for (i = 0; i < 170; i++) begin
        random_item();
        if (i == 85) drain();
      end
      drain();
    end

    // Mix a few more items around a purge down to one pair
    write_mask('0);
    idle_pct = 10; stall_pct = 10;
    for (i = 0; i < 8; i++) random_item();
    send(mk(CMD_PURGE, LOG_MAX, '0));
    for (i = 0; i < 8; i++) random_item();
    drain();

    $display("Sent %0d items, checked %0d responses, %0d appends hit a full ring.",
             n_sent, n_rcvd, n_full);
    $display("Covered four sample masks, all idle/stall mixes and a purge to one pair.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
